FILE: rtl/zph_pkg.sv
package zph_pkg;

   localparam int unsigned KeyCount   = 781;
   localparam int unsigned PieceKeys  = 768;
   localparam int unsigned FillWidth  = 10;
   localparam int unsigned CastleKeys = 4;
   localparam int unsigned PassantKeys = 8;

   // offsets of the extra keys above the piece keys
   localparam logic [3:0] SpecSide    = 4'd0;
   localparam logic [3:0] SpecCastle  = 4'd1;
   localparam logic [3:0] SpecPassant = 4'd5;
   localparam logic [3:0] SpecLast    = 4'd12;

   localparam logic [63:0] Seed = 64'h1234_5678_9ABC_DEF1;

   localparam int unsigned ShiftA = 13;
   localparam int unsigned ShiftB = 7;
   localparam int unsigned ShiftC = 17;

   localparam logic [2:0] KindLimit = 3'd6;

   typedef enum logic [1:0] {
      PHASE_FILL = 2'b01,
      PHASE_RUN  = 2'b10
   } phase_type;

   function automatic logic [63:0] xorshift(input logic [63:0] x);
      logic [63:0] y;
      y = x ^ (x << ShiftA);
      y = y ^ (y >> ShiftB);
      y = y ^ (y << ShiftC);
      return y;
   endfunction

endpackage

FILE: rtl/zobrist_position_hash.sv
// channel   | direction | ports
// ----------+-----------+-----------------------------------------------
// request   | in        | req_valid, req_ready, req_square_index .. req_passant_file
// response  | out       | rsp_valid, rsp_ready, rsp_position_hash
//
// after reset the key store is filled with 781 keys, one key a cycle;
// req_ready stays low until the fill is done.
// then one square request is taken every cycle while req_ready is high: one key store read and one xor.
// a last-square request's hash is formed from the s1 registers and written into a two-entry
// response queue, which lets requests flow while a hash waits; req_ready drops
// whenever that queue is about to hold two hashes.
module zobrist_position_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [5:0]  req_square_index,
   input  logic        req_occupied,
   input  logic        req_piece_colour,
   input  logic [2:0]  req_piece_kind,
   input  logic        req_last_square,
   input  logic        req_white_to_move,
   input  logic [3:0]  req_castling_rights,
   input  logic [3:0]  req_passant_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_position_hash
);

   zph_pkg::phase_type phase_ff, phase_in;
   logic [zph_pkg::FillWidth-1:0] fill_count_ff, fill_count_in;
   logic [63:0] gen_state_ff, gen_state_in;
   logic [63:0] new_key;
   logic        fill_wr;
   logic        piece_wr;
   logic [3:0]  spec_idx;
   logic [1:0]  castle_idx;
   logic [2:0]  passant_idx;

   logic [63:0] key_mem [zph_pkg::PieceKeys];
   logic [63:0] side_key_ff;
   logic [63:0] castle_key_ff [zph_pkg::CastleKeys];
   logic [63:0] passant_key_ff [zph_pkg::PassantKeys];

   logic        accept;
   logic [6:0]  sq_col;
   logic [9:0]  rd_addr;
   logic        occ_ok;
   logic [63:0] extra;

   logic        s1_valid_ff;
   logic        s1_last_ff;
   logic        s1_occ_ok_ff;
   logic [63:0] s1_extra_ff;
   logic [63:0] rdata_ff;

   logic [63:0] acc_ff, acc_in;
   logic [63:0] acc_sum;
   logic [63:0] result;

   logic [63:0] q_ff [2];
   logic [63:0] q_in [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic        pop;
   logic        push;
   logic [1:0]  base;
   logic [1:0]  occupancy;

   // key generation and fill
   assign new_key  = zph_pkg::xorshift(gen_state_ff);
   assign fill_wr  = (phase_ff == zph_pkg::PHASE_FILL);
   assign piece_wr = fill_wr && (fill_count_ff < zph_pkg::FillWidth'(zph_pkg::PieceKeys));
   assign spec_idx = 4'(fill_count_ff - zph_pkg::FillWidth'(zph_pkg::PieceKeys));
   assign castle_idx  = 2'(spec_idx - zph_pkg::SpecCastle);
   assign passant_idx = 3'(spec_idx - zph_pkg::SpecPassant);

   always_comb begin
      phase_in      = phase_ff;
      fill_count_in = fill_count_ff;
      gen_state_in  = gen_state_ff;
      if (fill_wr) begin
         gen_state_in  = new_key;
         fill_count_in = fill_count_ff + 1'b1;
         if (fill_count_ff == zph_pkg::FillWidth'(zph_pkg::KeyCount - 1)) begin
            phase_in = zph_pkg::PHASE_RUN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= zph_pkg::PHASE_FILL;
         fill_count_ff <= '0;
         gen_state_ff  <= zph_pkg::Seed;
      end else begin
         phase_ff      <= phase_in;
         fill_count_ff <= fill_count_in;
         gen_state_ff  <= gen_state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fill_wr && !piece_wr) begin
         case (spec_idx) inside
            zph_pkg::SpecSide: begin
               side_key_ff <= new_key;
            end
            [zph_pkg::SpecCastle:zph_pkg::SpecPassant - 4'd1]: begin
               castle_key_ff[castle_idx] <= new_key;
            end
            [zph_pkg::SpecPassant:zph_pkg::SpecLast]: begin
               passant_key_ff[passant_idx] <= new_key;
            end
            default: begin
            end
         endcase
      end
   end

   // request stage: address the piece key, gather the side/castling/passant keys
   assign accept = req_valid && req_ready;
   assign occ_ok = req_occupied && (req_piece_kind < zph_pkg::KindLimit);
   assign sq_col = {req_square_index, req_piece_colour};
   assign rd_addr = occ_ok ?
      (({3'b000, sq_col} << 2) + ({3'b000, sq_col} << 1) + {7'd0, req_piece_kind}) : '0;

   always_comb begin
      extra = req_white_to_move ? side_key_ff : '0;
      if (!req_passant_file[3]) begin
         extra = extra ^ passant_key_ff[req_passant_file[2:0]];
      end
      for (int b = 0; b < zph_pkg::CastleKeys; b++) begin
         if (req_castling_rights[b]) begin
            extra = extra ^ castle_key_ff[b];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (piece_wr) begin
         key_mem[fill_count_ff] <= new_key;
      end
      if (accept) begin
         rdata_ff <= key_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_last_ff   <= req_last_square;
         s1_occ_ok_ff <= occ_ok;
         s1_extra_ff  <= extra;
      end
   end

   // accumulate stage
   assign acc_sum = acc_ff ^ (s1_occ_ok_ff ? rdata_ff : 64'd0);
   assign result  = acc_sum ^ s1_extra_ff;

   always_comb begin
      acc_in = acc_ff;
      if (s1_valid_ff) begin
         acc_in = s1_last_ff ? 64'd0 : acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // response queue
   assign pop  = (cnt_ff != 2'd0) && rsp_ready;
   assign push = s1_valid_ff && s1_last_ff;
   assign base = cnt_ff - {1'b0, pop};
   assign occupancy = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push) begin
         q_in[base[0]] = result;
      end
      cnt_in = occupancy;
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign req_ready = (phase_ff == zph_pkg::PHASE_RUN) && (occupancy <= 2'd1);
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_position_hash = q_ff[0];

   a_no_request_during_fill: assert property (@(posedge clock) disable iff (reset)
      accept |-> (phase_ff == zph_pkg::PHASE_RUN))
      else $error("request taken before key fill finished");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2)
      else $error("response queue overflow");

   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_last_ff) |=> (acc_ff == 64'd0))
      else $error("accumulator not cleared after last square");

   a_run_sticks: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == zph_pkg::PHASE_RUN) |=> (phase_ff == zph_pkg::PHASE_RUN))
      else $error("left run phase without reset");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (base <= 2'd1))
      else $error("response pushed with no room");

endmodule
